// File: src/lsd_pkg.sv
// Package for the LZSS stream decoder: window geometry, token constants,
// and the history fill check. Used by lzss_stream_decoder_unit.
`default_nettype none
package lsd_pkg;

   localparam int WINDOW_DEPTH   = 4096;
   localparam int ADDR_W         = $clog2(WINDOW_DEPTH);
   localparam int MAX_COPY       = 18;
   localparam int MIN_MATCH_BIAS = 2;
   localparam int LEN_W          = $clog2(MAX_COPY + 1);
   localparam int COUNT_W        = 32;

   typedef logic [ADDR_W-1:0]  win_addr_type;
   typedef logic [LEN_W-1:0]   copy_len_type;
   typedef logic [COUNT_W-1:0] count_type;

   // write pointer after a stream clear
   localparam win_addr_type WP_START = win_addr_type'(WINDOW_DEPTH - MAX_COPY);
   localparam logic [3:0] LEN_MASK = 4'h0f;

   // Writes go strictly in order from WP_START, so an entry holds stream
   // data iff its distance from WP_START is below the number of bytes written.
   function automatic logic entry_written(input win_addr_type addr, input count_type produced);
      win_addr_type offset;
      begin
         offset = addr - WP_START;
         entry_written = (produced[COUNT_W-1:ADDR_W] != '0) ||
                         ({{(COUNT_W-ADDR_W){1'b0}}, offset} < produced);
      end
   endfunction

endpackage
`default_nettype wire

// File: src/lsd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none
module lsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: src/lzss_stream_decoder_unit.sv
// LZSS stream decoder, 4 KiB window. Top level; uses lsd_pkg and lsd_ram.
// One compressed word in, zero to eighteen decoded words out.
//
// Flag, literal and first-reference words are each taken when the output
// register is free or draining. A reference expands at one decoded word
// per cycle through the history RAM read port while the output is not
// stalled, giving its length (3 to 18) in words, fewer when the output
// limit cuts the copy short. The window needs no clearing pass: a fill
// count marks which entries hold stream data, so a new stream can start
// in the cycle after end_of_stream completes.
`default_nettype none
module lzss_stream_decoder_unit
   import lsd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_stream,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last_of_run,
   input  wire logic       csr_we,
   input  wire logic [31:0] csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_COPY = 1'b1;

   // control state
   logic         state_ff, state_in;
   win_addr_type wp_ff, wp_in;
   logic [7:0]   flag_ff, flag_in;
   logic [3:0]   bits_left_ff, bits_left_in;
   logic         phase_ff, phase_in;
   logic [7:0]   pos_low_ff, pos_low_in;
   count_type    produced_ff, produced_in;
   logic         halted_ff, halted_in;
   count_type    limit_ff;
   logic         eos_ff, eos_in;
   copy_len_type rem_ff, rem_in;
   win_addr_type rd_addr_ff, rd_addr_in;
   logic         rd_ok_ff, rd_ok_in;
   logic         fwd_ff, fwd_in;
   logic [7:0]   fwd_data_ff, fwd_data_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_byte_ff, rsp_byte_in;
   logic         rsp_last_ff, rsp_last_in;

   // history RAM port signals
   logic         wr_en;
   logic [7:0]   wr_data;
   logic         rd_en;
   win_addr_type rd_addr;
   logic [7:0]   rd_data;

   logic         out_free;
   logic         accept;
   logic         at_limit;
   logic         next_at_limit;
   logic         clear;
   logic [7:0]   copy_byte;
   win_addr_type ref_pos;
   logic         copy_last;

   lsd_ram #(
      .WIDTH(8),
      .DEPTH(WINDOW_DEPTH)
   ) u_history (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wp_ff),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign req_ready     = (state_ff == ST_IDLE) && out_free;
   assign accept        = req_valid && req_ready;
   assign at_limit      = produced_ff >= limit_ff;
   assign next_at_limit = (produced_ff + count_type'(1)) >= limit_ff;
   assign ref_pos       = {req_in_byte[7:4], pos_low_ff};
   // unwritten window entries read as zero; same-cycle write is forwarded
   assign copy_byte     = fwd_ff ? fwd_data_ff : (rd_ok_ff ? rd_data : 8'h00);
   assign copy_last     = (rem_ff == copy_len_type'(1)) || next_at_limit;

   // decode sequencer
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      flag_in      = flag_ff;
      bits_left_in = bits_left_ff;
      phase_in     = phase_ff;
      pos_low_in   = pos_low_ff;
      produced_in  = produced_ff;
      halted_in    = halted_ff;
      eos_in       = eos_ff;
      rem_in       = rem_ff;
      rd_addr_in   = rd_addr_ff;
      rd_ok_in     = rd_ok_ff;
      fwd_in       = 1'b0;
      fwd_data_in  = fwd_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_data      = copy_byte;
      rd_en        = 1'b0;
      rd_addr      = rd_addr_ff;
      clear        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               clear = req_end_of_stream;
               if (!halted_ff) begin
                  if (bits_left_ff == 4'd0) begin
                     flag_in      = req_in_byte;
                     bits_left_in = 4'd8;
                  end else if (flag_ff[0]) begin
                     // literal
                     flag_in      = flag_ff >> 1;
                     bits_left_in = bits_left_ff - 4'd1;
                     if (at_limit) begin
                        halted_in = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_byte_in  = req_in_byte;
                        rsp_last_in  = 1'b1;
                        wr_en        = 1'b1;
                        wr_data      = req_in_byte;
                        wp_in        = wp_ff + win_addr_type'(1);
                        produced_in  = produced_ff + count_type'(1);
                     end
                  end else if (!phase_ff) begin
                     pos_low_in = req_in_byte;
                     phase_in   = 1'b1;
                  end else begin
                     // reference: start the copy with the first window read
                     phase_in     = 1'b0;
                     flag_in      = flag_ff >> 1;
                     bits_left_in = bits_left_ff - 4'd1;
                     if (at_limit) begin
                        halted_in = 1'b1;
                     end else begin
                        clear      = 1'b0;
                        eos_in     = req_end_of_stream;
                        state_in   = ST_COPY;
                        rem_in     = copy_len_type'(req_in_byte[3:0] & LEN_MASK)
                                     + copy_len_type'(MIN_MATCH_BIAS + 1);
                        rd_en      = 1'b1;
                        rd_addr    = ref_pos;
                        rd_addr_in = ref_pos;
                        rd_ok_in   = entry_written(ref_pos, produced_ff);
                     end
                  end
               end
            end
         end
         ST_COPY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = copy_byte;
               rsp_last_in  = copy_last;
               wr_en        = 1'b1;
               wr_data      = copy_byte;
               wp_in        = wp_ff + win_addr_type'(1);
               produced_in  = produced_ff + count_type'(1);
               rem_in       = rem_ff - copy_len_type'(1);
               if (copy_last) begin
                  // limit cut the copy short: stop the stream
                  if (rem_ff != copy_len_type'(1)) begin
                     halted_in = 1'b1;
                  end
                  state_in = ST_IDLE;
                  clear    = eos_ff;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = rd_addr_ff + win_addr_type'(1);
                  rd_addr_in  = rd_addr;
                  rd_ok_in    = entry_written(rd_addr, produced_ff);
                  fwd_in      = (rd_addr == wp_ff);
                  fwd_data_in = copy_byte;
               end
            end else begin
               fwd_in = fwd_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // end of stream: back to the start state, window emptied by fill count
      if (clear) begin
         wp_in        = WP_START;
         flag_in      = 8'h00;
         bits_left_in = 4'd0;
         phase_in     = 1'b0;
         pos_low_in   = 8'h00;
         produced_in  = '0;
         halted_in    = 1'b0;
         eos_in       = 1'b0;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= WP_START;
         flag_ff      <= 8'h00;
         bits_left_ff <= 4'd0;
         phase_ff     <= 1'b0;
         pos_low_ff   <= 8'h00;
         produced_ff  <= '0;
         halted_ff    <= 1'b0;
         limit_ff     <= '0;
         eos_ff       <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         flag_ff      <= flag_in;
         bits_left_ff <= bits_left_in;
         phase_ff     <= phase_in;
         pos_low_ff   <= pos_low_in;
         produced_ff  <= produced_in;
         halted_ff    <= halted_in;
         eos_ff       <= eos_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      rd_addr_ff  <= rd_addr_in;
      rd_ok_ff    <= rd_ok_in;
      fwd_data_ff <= fwd_data_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule
`default_nettype wire
